[rtl/lot_pkg.sv]
// Package: request and response types and opcodes for the LRU order tracker.
package lot_pkg;

    localparam int ENTRY_W = 6;
    localparam int OCC_W   = 7;
    localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(2 ** ENTRY_W);

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_EVICT  = 1'b1;

    typedef struct packed {
        logic               op;
        logic [ENTRY_W-1:0] entry;
    } req_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] victim;
        logic               victim_valid;
        logic               was_present;
        logic [OCC_W-1:0]   occupancy;
    } rsp_t;

endpackage

[rtl/lot_order_row.sv]
// Row of recency cells: lookup, move-to-front shift, tail eviction and count.
module lot_order_row #(
    parameter int ENTRIES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  lot_pkg::req_t req,
    output lot_pkg::rsp_t rsp
);
    import lot_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // cell 0 is most recent; cells below count_reg are live
    logic [IDX_W-1:0] cell_reg  [ENTRIES];
    logic [IDX_W-1:0] cell_next [ENTRIES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [IDX_W-1:0]   entry_idx;
    logic               entry_ok;
    logic [ENTRIES-1:0] match;
    logic               hit;
    logic [IDX_W-1:0]   hit_pos;
    logic [IDX_W-1:0]   tail_pos;
    logic               do_access;
    logic               do_evict;

    assign entry_idx = IDX_W'(req.entry);
    assign entry_ok  = 32'(req.entry) < 32'(ENTRIES);
    assign tail_pos  = IDX_W'(count_reg - 1'b1);

    // parallel compare against every live cell
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] == entry_idx);
        end
    end

    assign hit = |match;

    // one-hot to binary
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_pos = hit_pos | (match[i] ? IDX_W'(i) : '0);
        end
    end

    assign do_access = (req.op == OP_ACCESS) && entry_ok;
    assign do_evict  = (req.op == OP_EVICT) && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (do_access && !hit)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_evict)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // hit: cells above the hit slide down one; miss: whole row slides
    always_comb
    begin
        cell_next[0] = do_access ? entry_idx : cell_reg[0];
        for (int i = 1; i < ENTRIES; i++)
        begin
            if (do_access && (!hit || (IDX_W'(i) <= hit_pos)))
            begin
                cell_next[i] = cell_reg[i-1];
            end
            else
            begin
                cell_next[i] = cell_reg[i];
            end
        end
    end

    always_comb
    begin
        rsp.victim       = do_evict ? ENTRY_W'(cell_reg[tail_pos]) : '0;
        rsp.victim_valid = do_evict;
        rsp.was_present  = do_access && hit;
        rsp.occupancy    = OCC_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
        end
    end

endmodule

[rtl/lru_order_tracker_unit.sv]
// Top level of the LRU order tracker: request register, order row, response register.
//
// Tracks the recency order of entry indices. Each request on the req channel is
// either an access (op = 0: move entry to the front, insert it if absent) or an
// evict (op = 1: drop the least recently used entry and report it).
// Every request gives exactly one response on the rsp channel.
// Both channels use valid/stall: a transfer happens on a rising edge with valid
// high and stall low.
// A taken request is held in the request register, processed by the order row
// and written to the response register when that register is free.
// Throughput: one request per cycle while rsp_stall is low. The order is kept in
// a row of cells that shift in one step with a parallel compare, so no request
// waits on another. When rsp_stall is high the response register holds. One further
// request may wait in the request register; after that req_stall rises.
// Reset (rst_n low, asynchronous) empties the list and both registers.
// Cell contents are not cleared, since only cells below the count are ever read.
module lru_order_tracker_unit #(
    parameter int ENTRIES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lot_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lot_pkg::rsp_t rsp
);
    import lot_pkg::*;

    // request register
    logic req_vld_reg;
    logic req_vld_next;
    req_t req_reg;

    // response register
    logic rsp_vld_reg;
    logic rsp_vld_next;
    rsp_t rsp_reg;
    rsp_t row_rsp;

    logic advance;
    logic take;

    // the held request moves on whenever the response register is free
    assign advance   = req_vld_reg && (!rsp_vld_reg || !rsp_stall);
    assign req_stall = req_vld_reg && !advance;
    assign take      = req_valid && !req_stall;

    always_comb
    begin
        req_vld_next = req_vld_reg;
        if (take)
        begin
            req_vld_next = 1'b1;
        end
        else if (advance)
        begin
            req_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_vld_next = rsp_vld_reg;
        if (advance)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    lot_order_row #(
        .ENTRIES (ENTRIES)
    ) u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (req_reg),
        .rsp   (row_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= row_rsp;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/lot_checker.sv]
// Port-level checks for the LRU order tracker, bound to the top level.
module lot_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input lot_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input lot_pkg::rsp_t rsp
);
    import lot_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("request stalled with empty response register");

    a_evict_not_present: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.victim_valid |-> !rsp.was_present)
        else $error("eviction flagged as hit");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.victim_valid |-> (rsp.victim == '0) && (rsp.occupancy <= OCC_MAX))
        else $error("victim or occupancy out of range");

endmodule

bind lru_order_tracker_unit lot_checker u_lot_checker (.*);
